[sv/joint_velocity_limit_projector_unit_defines.svh]
// Assertion macros for the joint velocity limit projector.
// Each macro takes a label, an antecedent and a consequent, and expects clk and arst_n in scope.
`ifndef JOINT_VELOCITY_LIMIT_PROJECTOR_UNIT_DEFINES_SVH
`define JOINT_VELOCITY_LIMIT_PROJECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define JVLP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jvlp: same-cycle check failed");
`define JVLP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jvlp: next-cycle check failed");
`else
`define JVLP_ASSERT_NOW(lbl, ante, cons)
`define JVLP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/jvlp_pkg.sv]
`default_nettype none

package jvlp_pkg;

	// action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_PROJECT = 1'b1;

	// limit word lanes within a joint's row
	localparam logic [1:0] LIM_VMAX = 2'd0;
	localparam logic [1:0] LIM_VMIN = 2'd1;
	localparam logic [1:0] LIM_QMIN = 2'd2;
	localparam logic [1:0] LIM_QMAX = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_STEP_TIME    = 2'd0;
	localparam logic [1:0] CFG_ELBOW_EN     = 2'd1;
	localparam logic [1:0] CFG_ELBOW_MARGIN = 2'd2;

	localparam logic [3:0] ELBOW_JOINT = 4'd2;

	typedef struct packed {
		logic               action;
		logic [3:0]         joint;
		logic [1:0]         limit_select;
		logic signed [15:0] limit_value;
		logic signed [15:0] position;
		logic signed [15:0] desired_velocity;
	} cmd_t;

	typedef struct packed {
		logic [3:0]         joint_out;
		logic signed [15:0] safe_velocity;
	} res_t;

	typedef enum logic [1:0] {
		FAC_ZERO,
		FAC_RAMP,
		FAC_ONE
	} fac_sel_t;

	typedef enum logic [1:0] {
		ELB_NONE,
		ELB_PUSH,
		ELB_SCALE
	} elb_sel_t;

	// per-item data that rides alongside the arithmetic stages
	typedef struct packed {
		logic [3:0]         joint;
		logic               oor;
		logic               elbow_on;
		logic signed [15:0] pos;
		logic signed [15:0] qmin;
		logic signed [15:0] qmax;
		logic signed [15:0] vc;
		fac_sel_t           fac_sel;
		elb_sel_t           elb_sel;
	} side_t;

endpackage

`default_nettype wire

[sv/jvlp_limit_mem.sv]
`default_nettype none

// One row per joint, four 16-bit limit words per row; lane write, registered row read.
module jvlp_limit_mem #(
	parameter int ROWS = 5,
	localparam int RW = $clog2(ROWS)
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [RW-1:0]       wr_row,
	input  wire logic [1:0]          wr_lane,
	input  wire logic [15:0]         wr_data,
	input  wire logic                rd_en,
	input  wire logic [RW-1:0]       rd_row,
	output logic      [3:0][15:0]    rd_data
);

	logic [3:0][15:0] mem_q [ROWS];
	logic [3:0][15:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_row][wr_lane] <= wr_data;
		end
	end

	// hold the read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_row];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[sv/jvlp_quad_factor.sv]
`default_nettype none

// fac = (floor(x * 2^FRAC / DIVISOR))^2 >> FRAC, three stages, advancing on adv.
// The quotient comes from a reciprocal multiply and one correction step.
module jvlp_quad_factor #(
	parameter int FRAC = 12,
	parameter int DIVISOR = 328,
	localparam int XW = $clog2(DIVISOR)
) (
	input  wire logic            clk,
	input  wire logic            adv,
	input  wire logic [XW-1:0]   x,
	output logic      [FRAC-1:0] fac
);

	localparam int NW = XW + FRAC;
	localparam int RW = FRAC + 1;
	localparam int PW = XW + RW;
	localparam int RECIP = (1 << NW) / DIVISOR;

	logic [PW-1:0]     prod_a;
	logic [NW-1:0]     prod_b;
	logic [NW:0]       rem;
	logic [FRAC-1:0]   quo;
	logic [2*FRAC-1:0] sq;

	logic [FRAC-1:0] est_s1;
	logic [XW-1:0]   x_s1;
	logic [FRAC-1:0] quo_s2;
	logic [FRAC-1:0] fac_s3;

	// estimate is the true quotient or one below it
	assign prod_a = PW'(x) * PW'(RECIP);
	assign prod_b = NW'(est_s1) * NW'(DIVISOR);
	assign rem    = (NW+1)'({x_s1, {FRAC{1'b0}}}) - (NW+1)'(prod_b);
	assign quo    = (rem >= (NW+1)'(DIVISOR)) ? est_s1 + FRAC'(1) : est_s1;
	assign sq     = quo_s2 * quo_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			est_s1 <= FRAC'(prod_a >> XW);
			x_s1   <= x;
			quo_s2 <= quo;
			fac_s3 <= FRAC'(sq >> FRAC);
		end
	end

	assign fac = fac_s3;

endmodule

`default_nettype wire

[sv/joint_velocity_limit_projector_unit.sv]
// Joint velocity limit projector. Each projection item (action 1) carries one joint's angle and
// requested rate and yields one result with the safe rate; each load item (action 0) writes one
// limit word (max rate, min rate, min angle, max angle) of one joint and yields nothing. All four
// limits of a joint must be loaded before that joint is projected; the table has no reset and is
// never swept. Loads to a joint at or above JOINT_COUNT are dropped, and projections of such a
// joint return zero. The block takes one item per clock while the result side is not stalled: the
// limit table is one row per joint, read as a whole row through a single registered port, so one
// row read per cycle sets the rate. A load may be followed in the very next cycle by a projection
// of the same joint; the written word is already visible to that read. A projection's result is
// registered through the table read, the clamp and classification, two constant-divider stages, a
// squaring stage, the rate scaling, the look-ahead step and the final limit and elbow selection.
// A stalled result freezes the whole pipeline and raises cmd_stall. Configuration writes are
// always taken (cfg_ready is tied high) and must only come while no projection is in flight.
`default_nettype none

`include "joint_velocity_limit_projector_unit_defines.svh"

module joint_velocity_limit_projector_unit #(
	parameter int JOINT_COUNT = 5,
	parameter int FRACTION_BITS = 12
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire jvlp_pkg::cmd_t  cmd,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output jvlp_pkg::res_t       res,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [15:0]     cfg_data
);

	localparam int F = FRACTION_BITS;
	localparam int ROW_W = $clog2(JOINT_COUNT);
	localparam int ONE = 1 << F;
	localparam int OUTER = (ONE + 5) / 10;
	localparam int INNER = (ONE + 25) / 50;
	localparam int BAND = (ONE + 2) / 5;
	localparam int XWR = $clog2(OUTER - INNER);
	localparam int XWE = $clog2(BAND);

	localparam logic signed [17:0] INNER_C = 18'(INNER);
	localparam logic signed [17:0] OUTER_C = 18'(OUTER);
	localparam logic signed [17:0] BAND_C  = 18'(BAND);
	localparam logic signed [15:0] PUSH_C  = 16'(-(ONE / 2));
	localparam logic [F:0]         ONE_C   = (F+1)'(ONE);

	function automatic logic [16:0] mag17(input logic signed [15:0] a);
		mag17 = a[15] ? 17'(-(17'(a))) : 17'(a);
	endfunction

	// ---------------------------------------------------------------- configuration
	logic [15:0] step_time_q;
	logic        elbow_en_q;
	logic [14:0] margin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= 16'd655;
			elbow_en_q  <= 1'b0;
			margin_q    <= 15'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jvlp_pkg::CFG_STEP_TIME:    step_time_q <= cfg_data;
				jvlp_pkg::CFG_ELBOW_EN:     elbow_en_q  <= cfg_data[0];
				jvlp_pkg::CFG_ELBOW_MARGIN: margin_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	// One advance signal moves every stage; a held result freezes them all.
	logic adv;
	logic accept;
	logic cmd_oor;
	logic res_valid_q;

	assign adv       = !res_valid_q || !res_stall;
	assign cmd_stall = !adv;
	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_oor   = 5'(cmd.joint) >= 5'(JOINT_COUNT);

	// ---------------------------------------------------------------- limit table
	// Write a load at its accepting edge; read the projected joint's row at its accepting edge.
	logic [3:0][15:0] row_s1;

	jvlp_limit_mem #(
		.ROWS(JOINT_COUNT)
	) u_mem (
		.clk     (clk),
		.wr_en   (accept && cmd.action == jvlp_pkg::ACT_LOAD && !cmd_oor),
		.wr_row  (cmd.joint[ROW_W-1:0]),
		.wr_lane (cmd.limit_select),
		.wr_data (cmd.limit_value),
		.rd_en   (accept && cmd.action == jvlp_pkg::ACT_PROJECT && !cmd_oor),
		.rd_row  (cmd.joint[ROW_W-1:0]),
		.rd_data (row_s1)
	);

	// ---------------------------------------------------------------- stage 1
	logic           vld_s1;
	jvlp_pkg::cmd_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			// loads never enter the pipeline
			vld_s1 <= accept && cmd.action == jvlp_pkg::ACT_PROJECT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd;
		end
	end

	// Clamp to the rate window (min last, so it wins on an inverted window), find the
	// distance to the limit the rate heads for, and classify both the joint margin and
	// the elbow band.
	logic signed [15:0] vmax, vmin, qmin, qmax, v_hi, vc;
	logic signed [16:0] lim_gap;
	logic signed [17:0] dist_r;
	logic signed [17:0] dist_e;
	logic [XWR-1:0]     x_ramp_d;
	logic [XWE-1:0]     x_elb_d;
	jvlp_pkg::side_t    side_d;

	always_comb begin
		vmax = $signed(row_s1[jvlp_pkg::LIM_VMAX]);
		vmin = $signed(row_s1[jvlp_pkg::LIM_VMIN]);
		qmin = $signed(row_s1[jvlp_pkg::LIM_QMIN]);
		qmax = $signed(row_s1[jvlp_pkg::LIM_QMAX]);
		v_hi = (cmd_s1.desired_velocity > vmax) ? vmax : cmd_s1.desired_velocity;
		vc   = (v_hi < vmin) ? vmin : v_hi;

		lim_gap = vc[15] ? 17'(cmd_s1.position) - 17'(qmin)
		                 : 17'(qmax) - 17'(cmd_s1.position);
		dist_r  = 18'(lim_gap);
		dist_e  = -$signed({3'b000, margin_q}) - 18'(cmd_s1.position);

		x_ramp_d = XWR'(dist_r - INNER_C);
		x_elb_d  = XWE'(dist_e);

		side_d.joint    = cmd_s1.joint;
		side_d.oor      = 5'(cmd_s1.joint) >= 5'(JOINT_COUNT);
		side_d.elbow_on = elbow_en_q && cmd_s1.joint == jvlp_pkg::ELBOW_JOINT;
		side_d.pos      = cmd_s1.position;
		side_d.qmin     = qmin;
		side_d.qmax     = qmax;
		side_d.vc       = vc;

		// a zero rate needs no scaling
		if (vc == 16'sd0) begin
			side_d.fac_sel = jvlp_pkg::FAC_ONE;
		end else if (dist_r < INNER_C) begin
			side_d.fac_sel = jvlp_pkg::FAC_ZERO;
		end else if (dist_r < OUTER_C) begin
			side_d.fac_sel = jvlp_pkg::FAC_RAMP;
		end else begin
			side_d.fac_sel = jvlp_pkg::FAC_ONE;
		end

		// at or past the elbow limit push back; inside the band slow down
		if (dist_e <= 18'sd0) begin
			side_d.elb_sel = jvlp_pkg::ELB_PUSH;
		end else if (dist_e < BAND_C) begin
			side_d.elb_sel = jvlp_pkg::ELB_SCALE;
		end else begin
			side_d.elb_sel = jvlp_pkg::ELB_NONE;
		end
	end

	// ---------------------------------------------------------------- stages 2 to 5
	// Both quadratic factors come out of their units aligned with stage 5.
	logic            vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	jvlp_pkg::side_t side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [XWR-1:0]  x_ramp_s2;
	logic [XWE-1:0]  x_elb_s2;
	logic [F-1:0]    ramp_fac_s5;
	logic [F-1:0]    elb_fac_s5;

	jvlp_quad_factor #(
		.FRAC    (F),
		.DIVISOR (OUTER - INNER)
	) u_ramp (
		.clk (clk),
		.adv (adv),
		.x   (x_ramp_s2),
		.fac (ramp_fac_s5)
	);

	jvlp_quad_factor #(
		.FRAC    (F),
		.DIVISOR (BAND)
	) u_elbow (
		.clk (clk),
		.adv (adv),
		.x   (x_elb_s2),
		.fac (elb_fac_s5)
	);

	// ---------------------------------------------------------------- stage 5: scale the rate
	logic [F:0]         factor;
	logic [16:0]        mag5;
	logic [17+F:0]      prod5;
	logic [16:0]        p5;
	logic signed [16:0] sv5;

	always_comb begin
		case (side_s5.fac_sel)
			jvlp_pkg::FAC_ZERO: factor = '0;
			jvlp_pkg::FAC_RAMP: factor = {1'b0, ramp_fac_s5};
			default:            factor = ONE_C;
		endcase
		mag5  = mag17(side_s5.vc);
		prod5 = (18+F)'(mag5) * (18+F)'(factor);
		// the factor never exceeds one, so the magnitude fits without saturation
		p5  = 17'(prod5 >> F);
		sv5 = side_s5.vc[15] ? -$signed(p5) : $signed(p5);
	end

	// ---------------------------------------------------------------- stage 6: look ahead
	logic signed [15:0] v_s6;
	logic [F-1:0]       sq_s6;
	logic [16:0]        mag6;
	logic [32:0]        prod6;
	logic [15:0]        p6;
	logic signed [16:0] step6;
	logic signed [17:0] nxt6;

	always_comb begin
		mag6  = mag17(v_s6);
		prod6 = 33'(mag6) * 33'(step_time_q);
		p6    = 16'(prod6 >> 16);
		step6 = v_s6[15] ? -$signed({1'b0, p6}) : $signed({1'b0, p6});
		nxt6  = 18'(side_s6.pos) + 18'(step6);
	end

	// ---------------------------------------------------------------- stage 7: final selection
	logic signed [15:0] v_s7;
	logic signed [17:0] nxt_s7;
	logic [F-1:0]       sq_s7;
	logic               vpos7;
	logic               zero7;
	logic [14+F:0]      prod7;
	logic [14:0]        sc7;
	logic signed [15:0] vout7;

	always_comb begin
		vpos7 = !v_s7[15] && v_s7 != 16'sd0;
		zero7 = (nxt_s7 < 18'(side_s7.qmin) && v_s7[15])
		     || (nxt_s7 > 18'(side_s7.qmax) && vpos7);
		prod7 = (15+F)'(v_s7[14:0]) * (15+F)'(sq_s7);
		sc7   = 15'(prod7 >> F);

		if (side_s7.oor || zero7) begin
			vout7 = '0;
		end else if (side_s7.elbow_on && vpos7) begin
			// a positive rate that would open the elbow past zero is blocked outright
			if (nxt_s7 > 18'sd0) begin
				vout7 = '0;
			end else begin
				case (side_s7.elb_sel)
					jvlp_pkg::ELB_PUSH:  vout7 = PUSH_C;
					jvlp_pkg::ELB_SCALE: vout7 = $signed({1'b0, sc7});
					default:             vout7 = v_s7;
				endcase
			end
		end else begin
			vout7 = v_s7;
		end
	end

	// ---------------------------------------------------------------- pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_s7      <= vld_s6;
			res_valid_q <= vld_s7;
		end
	end

	jvlp_pkg::res_t res_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2   <= side_d;
			x_ramp_s2 <= x_ramp_d;
			x_elb_s2  <= x_elb_d;
			side_s3   <= side_s2;
			side_s4   <= side_s3;
			side_s5   <= side_s4;
			side_s6   <= side_s5;
			v_s6      <= 16'(sv5);
			sq_s6     <= elb_fac_s5;
			side_s7   <= side_s6;
			v_s7      <= v_s6;
			nxt_s7    <= nxt6;
			sq_s7     <= sq_s6;
			res_q.joint_out     <= side_s7.joint;
			res_q.safe_velocity <= vout7;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------------------------------------------------------- assertions
	// a load item never starts a projection
	`JVLP_ASSERT_NEXT(a_load_silent, accept && cmd.action == jvlp_pkg::ACT_LOAD, !vld_s1)
	// a frozen pipeline keeps its first stage
	`JVLP_ASSERT_NEXT(a_s1_hold, cmd_stall, vld_s1 == $past(vld_s1))
	// a joint beyond the table always yields a zero rate
	`JVLP_ASSERT_NOW(a_oor_zero, res_valid && 5'(res.joint_out) >= 5'(JOINT_COUNT), res.safe_velocity == 16'sd0)

endmodule

`default_nettype wire
